// File: hw/rtl/motion_profile_generator_defines.svh
// Assertion macros shared by the motion profile generator RTL.
`ifndef MOTION_PROFILE_GENERATOR_DEFINES_SVH
`define MOTION_PROFILE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define MPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define MPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mpg_pkg.sv
// Types, codes and helpers shared by the motion profile generator.
package mpg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_EXTRA = 16;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_TARGET = 2'd1;
   localparam logic [1:0] MODE_RESET  = 2'd2;

   localparam logic [1:0] PROF_DISABLED = 2'd0;
   localparam logic [1:0] PROF_TRAP     = 2'd1;

   localparam logic [2:0] CSR_PROFILE = 3'd0;
   localparam logic [2:0] CSR_RATE    = 3'd1;
   localparam logic [2:0] CSR_ACCEL   = 3'd2;
   localparam logic [2:0] CSR_JERK    = 3'd3;
   localparam logic [2:0] CSR_TOL     = 3'd4;
   localparam logic [2:0] CSR_PERIOD  = 3'd5;

   localparam logic [30:0] TOL_RESET     = 31'd66;
   localparam logic [30:0] TOL_DEFAULT   = 31'(((1 << FRAC_BITS) + 500) / 1000);
   localparam logic [31:0] PERIOD_RESET  = 32'd429497;
   localparam logic [31:0] HOLD_PERIOD   = 32'd4295;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               busy_res;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic [1:0] op;
   } arith_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (!x[33] && x[32:31] != 2'b00) begin
         r = 32'sh7FFFFFFF;
      end else if (x[33] && x[32:31] != 2'b11) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/mpg_arith.sv
// Shared serial unit: shift-add multiply, restoring divide and square root.
module mpg_arith import mpg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type req,
   input  logic [64:0]   opa,
   input  logic [31:0]   opb,
   output logic          done,
   output logic [64:0]   result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  op_ff, op_in;
   logic [5:0]  count_ff, count_in;
   logic [65:0] acc_ff, acc_in;
   logic [36:0] part_ff, part_in;
   logic [32:0] root_ff, root_in;
   logic [32:0] opd_ff, opd_in;

   logic [36:0] add_x, add_y;
   logic        add_sub;
   logic [37:0] add_sum;
   logic        ge;

   // one adder serves every operation
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (op_ff)
         OP_MUL: begin
            add_x = {4'b0, acc_ff[64:32]};
            add_y = acc_ff[0] ? {4'b0, opd_ff} : 37'd0;
         end
         OP_DIV: begin
            add_x   = {4'b0, part_ff[31:0], 1'b0};
            add_y   = {4'b0, opd_ff};
            add_sub = 1'b1;
         end
         OP_SQRT: begin
            add_x   = {part_ff[34:0], acc_ff[65:64]};
            add_y   = {2'b0, root_ff, 2'b01};
            add_sub = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
      add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {37'd0, add_sub};
      ge      = add_sum[37];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      part_in  = part_ff;
      root_in  = root_ff;
      opd_in   = opd_ff;
      if (req.go && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = req.op;
         root_in = '0;
         case (req.op)
            OP_MUL: begin
               acc_in   = {33'd0, opb};
               opd_in   = opa[32:0];
               count_in = 6'd31;
            end
            OP_DIV: begin
               part_in  = {5'b0, opa[30:0], 1'b0};
               opd_in   = {1'b0, opb};
               count_in = 6'd30;
            end
            default: begin
               acc_in   = {1'b0, opa};
               part_in  = '0;
               count_in = 6'd32;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               acc_in = {1'b0, add_sum[33:0], acc_ff[31:1]};
            end
            OP_DIV: begin
               part_in = ge ? {4'b0, add_sum[32:0]} : {4'b0, part_ff[31:0], 1'b0};
               root_in = {root_ff[31:0], ge};
            end
            default: begin
               part_in = ge ? add_sum[36:0] : add_x;
               root_in = {root_ff[31:0], ge};
               acc_in  = {acc_ff[63:0], 2'b00};
            end
         endcase
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      part_ff  <= part_in;
      root_ff  <= root_in;
      opd_ff   <= opd_in;
   end

   always_comb begin
      case (op_ff)
         OP_MUL:  result = acc_ff[64:0];
         OP_DIV:  result = {34'd0, root_ff[30:0]};
         default: result = {32'd0, root_ff};
      endcase
   end

   assign done = done_ff;

endmodule

// File: hw/rtl/motion_profile_generator.sv
// Motion profile generator: trajectory planner top level with sequencer and state.
//
// Input words on req_ (mode, value): tick, set target, or reset position to value.
// Each input word yields exactly one rsp_ word: held position, velocity,
// acceleration and the busy flag. Configuration words on csr_ (index, data)
// are always taken and must only arrive while the block is idle.
// Set target, reset, ignored, disabled and held-period ticks go from decode
// to the emit step, which raises rsp_valid once the output register is free.
// A planning tick runs through one shared serial unit (32-step multiply,
// 31-step divide, 33-step square root); each operation holds the sequencer
// until the unit is done. A trapezoid tick uses four multiplies, and a root
// when braking; an s-curve tick uses up to six multiplies, one root, one divide.
// One word is in work at a time; req_ready is high only while the sequencer
// idles, so the next word can be taken in the cycle rsp_valid rises. The result
// sits in an output register: a new word can be taken while it waits, and the
// sequencer holds its final step until rsp_ready frees it.
// Reset clears the plan to zero and loads register defaults (tolerance 66,
// period 429497); no word is pending afterwards.
module motion_profile_generator import mpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

`include "motion_profile_generator_defines.svh"

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MDD    = 4'd2;
   localparam logic [3:0] S_MRR    = 4'd3;
   localparam logic [3:0] S_SQRT   = 4'd4;
   localparam logic [3:0] S_TGT    = 4'd5;
   localparam logic [3:0] S_MADT   = 4'd6;
   localparam logic [3:0] S_TRAP   = 4'd7;
   localparam logic [3:0] S_SCURVE = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_MJDT   = 4'd10;
   localparam logic [3:0] S_JERK   = 4'd11;
   localparam logic [3:0] S_MADV   = 4'd12;
   localparam logic [3:0] S_MRDT   = 4'd13;
   localparam logic [3:0] S_POS    = 4'd14;
   localparam logic [3:0] S_EMIT   = 4'd15;

   logic [3:0]  state_ff, state_in;
   logic        launched_ff, launched_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [1:0]  profile_ff;
   logic [30:0] rate_lim_ff, accel_lim_ff, jerk_lim_ff, tol_ff;
   logic [31:0] period_ff;

   logic signed [31:0] goal_ff, goal_in;
   logic signed [47:0] pos_ff, pos_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [31:0] accel_ff, accel_in;
   logic               moving_ff, moving_in;
   logic signed [31:0] hpos_ff, hpos_in, hrate_ff, hrate_in, haccel_ff, haccel_in;

   logic [1:0]         mode_ff, mode_in;
   logic signed [31:0] value_ff, value_in;
   logic [48:0]        dext_ff, dext_in;
   logic               dpos_ff, dpos_in, dneg_ff, dneg_in;
   logic [64:0]        p1_ff, p1_in;
   logic [30:0]        lim_ff, lim_in;
   logic signed [32:0] rerr_ff, rerr_in;
   logic [62:0]        adt_ff, adt_in;
   logic [30:0]        tm_ff, tm_in;
   logic [30:0]        step_ff, step_in;
   logic [46:0]        dmag_ff, dmag_in;

   arith_req_type arith_req;
   logic [64:0]   arith_opa, arith_result;
   logic [31:0]   arith_opb;
   logic          arith_done, arith_state;

   logic signed [31:0] goal_src;
   logic signed [47:0] goal_ext;
   logic signed [48:0] diff;
   logic [48:0]        dext_c, tol_ext;
   logic [30:0]        tol;
   logic [31:0]        rate_mag, accel_mag;
   logic [32:0]        em;

   logic signed [31:0] lim_s, trate, td;
   logic signed [32:0] step_s, clip, derr, dvs;
   logic signed [48:0] ds, pos_sum;
   logic signed [47:0] pos_new;

   mpg_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (arith_req),
      .opa    (arith_opa),
      .opb    (arith_opb),
      .done   (arith_done),
      .result (arith_result)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      goal_src  = (mode_ff == MODE_TICK) ? goal_ff : value_ff;
      goal_ext  = {goal_src, 16'd0};
      diff      = {goal_ext[47], goal_ext} - {pos_ff[47], pos_ff};
      dext_c    = diff[48] ? 49'(-diff) : 49'(diff);
      tol       = (tol_ff == 31'd0) ? TOL_DEFAULT : tol_ff;
      tol_ext   = {2'b0, tol, 16'd0};
      rate_mag  = rate_ff[31] ? 32'(-rate_ff) : 32'(rate_ff);
      accel_mag = accel_ff[31] ? 32'(-accel_ff) : 32'(accel_ff);
      em        = rerr_ff[32] ? 33'(-rerr_ff) : 33'(rerr_ff);
   end

   // operand select for the shared unit
   always_comb begin
      arith_state   = (state_ff inside {S_MDD, S_MRR, S_SQRT, S_MADT, S_DIV, S_MJDT,
                                        S_MADV, S_MRDT});
      arith_req.go  = arith_state && !launched_ff;
      arith_req.op  = OP_MUL;
      arith_opa     = '0;
      arith_opb     = period_ff;
      case (state_ff)
         S_MDD: begin
            arith_opa = {32'd0, dext_ff[48:16]};
            arith_opb = {accel_lim_ff, 1'b0};
         end
         S_MRR: begin
            arith_opa = {33'd0, rate_mag};
            arith_opb = rate_mag;
         end
         S_SQRT: begin
            arith_req.op = OP_SQRT;
            arith_opa    = p1_ff;
         end
         S_MADT:  arith_opa = {34'd0, accel_lim_ff};
         S_DIV: begin
            arith_req.op = OP_DIV;
            arith_opa    = {34'd0, em[30:0]};
         end
         S_MJDT:  arith_opa = {34'd0, jerk_lim_ff};
         S_MADV:  arith_opa = {33'd0, accel_mag};
         S_MRDT:  arith_opa = {33'd0, rate_mag};
         default: arith_opa = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      goal_in      = goal_ff;
      pos_in       = pos_ff;
      rate_in      = rate_ff;
      accel_in     = accel_ff;
      moving_in    = moving_ff;
      hpos_in      = hpos_ff;
      hrate_in     = hrate_ff;
      haccel_in    = haccel_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      dext_in      = dext_ff;
      dpos_in      = dpos_ff;
      dneg_in      = dneg_ff;
      p1_in        = p1_ff;
      lim_in       = lim_ff;
      rerr_in      = rerr_ff;
      adt_in       = adt_ff;
      tm_in        = tm_ff;
      step_in      = step_ff;
      dmag_in      = dmag_ff;

      lim_s   = {1'b0, lim_ff};
      trate   = dpos_ff ? lim_s : (dneg_ff ? -lim_s : 32'sd0);
      step_s  = {2'b0, step_ff};
      td      = rerr_ff[32] ? -$signed({1'b0, tm_ff}) : $signed({1'b0, tm_ff});
      derr    = {td[31], td} - {accel_ff[31], accel_ff};
      clip    = '0;
      dvs     = accel_ff[31] ? -$signed({2'b0, arith_result[62:32]})
                             : $signed({2'b0, arith_result[62:32]});
      ds      = rate_ff[31] ? -$signed({2'b0, dmag_ff}) : $signed({2'b0, dmag_ff});
      pos_sum = {pos_ff[47], pos_ff} + ds;
      if (pos_sum[48] != pos_sum[47]) begin
         pos_new = pos_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         pos_new = pos_sum[47:0];
      end

      if (arith_req.go) begin
         launched_in = 1'b1;
      end
      if (arith_done) begin
         launched_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               value_in = req_data.value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            case (mode_ff)
               MODE_TICK: begin
                  if (profile_ff == PROF_DISABLED) begin
                     hpos_in   = goal_ff;
                     hrate_in  = '0;
                     haccel_in = '0;
                     moving_in = 1'b0;
                  end else if (period_ff > HOLD_PERIOD) begin
                     dext_in  = dext_c;
                     dpos_in  = !diff[48] && (diff != 49'sd0);
                     dneg_in  = diff[48];
                     state_in = S_MDD;
                  end
               end
               MODE_TARGET: begin
                  goal_in   = value_ff;
                  moving_in = dext_c > tol_ext;
               end
               MODE_RESET: begin
                  goal_in   = value_ff;
                  pos_in    = {value_ff, 16'd0};
                  rate_in   = '0;
                  accel_in  = '0;
                  moving_in = 1'b0;
               end
               default: begin
                  moving_in = moving_ff;
               end
            endcase
         end
         S_MDD: begin
            if (arith_done) begin
               p1_in    = arith_result;
               state_in = S_MRR;
            end
         end
         S_MRR: begin
            if (arith_done) begin
               // brake once the stop distance reaches the remaining distance
               if ((accel_lim_ff != 31'd0) ? (p1_ff <= arith_result)
                                           : (dext_ff[48:16] == 33'd0)) begin
                  state_in = S_SQRT;
               end else begin
                  lim_in   = rate_lim_ff;
                  state_in = S_TGT;
               end
            end
         end
         S_SQRT: begin
            if (arith_done) begin
               lim_in   = (arith_result[32:31] != 2'b00) ? {31{1'b1}} : arith_result[30:0];
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            rerr_in  = {trate[31], trate} - {rate_ff[31], rate_ff};
            state_in = S_MADT;
         end
         S_MADT: begin
            if (arith_done) begin
               adt_in   = arith_result[62:0];
               state_in = (profile_ff == PROF_TRAP) ? S_TRAP : S_SCURVE;
            end
         end
         S_TRAP: begin
            step_s = {2'b0, adt_ff[62:32]};
            if (rerr_ff > step_s) begin
               clip = step_s;
            end else if (rerr_ff < -step_s) begin
               clip = -step_s;
            end else begin
               clip = rerr_ff;
            end
            rate_in  = sat32({clip[32], clip} + {{2{rate_ff[31]}}, rate_ff});
            accel_in = '0;
            state_in = S_MRDT;
         end
         S_SCURVE: begin
            if (em[32:31] != 2'b00 || {em[30:0], 32'd0} >= adt_ff) begin
               tm_in    = accel_lim_ff;
               state_in = S_MJDT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (arith_done) begin
               tm_in    = arith_result[30:0];
               state_in = S_MJDT;
            end
         end
         S_MJDT: begin
            if (arith_done) begin
               step_in  = arith_result[62:32];
               state_in = S_JERK;
            end
         end
         S_JERK: begin
            if (derr > step_s) begin
               clip = step_s;
            end else if (derr < -step_s) begin
               clip = -step_s;
            end else begin
               clip = derr;
            end
            accel_in = sat32({clip[32], clip} + {{2{accel_ff[31]}}, accel_ff});
            state_in = S_MADV;
         end
         S_MADV: begin
            if (arith_done) begin
               rate_in  = sat32({dvs[32], dvs} + {{2{rate_ff[31]}}, rate_ff});
               state_in = S_MRDT;
            end
         end
         S_MRDT: begin
            if (arith_done) begin
               dmag_in  = arith_result[62:16];
               state_in = S_POS;
            end
         end
         S_POS: begin
            hpos_in   = pos_new[47:16];
            hrate_in  = rate_ff;
            haccel_in = accel_ff;
            // arrival uses the distance from before this step; snap on arrival
            if (dext_ff <= tol_ext && rate_mag <= {1'b0, tol}) begin
               pos_in    = {goal_ff, 16'd0};
               rate_in   = '0;
               accel_in  = '0;
               moving_in = 1'b0;
            end else begin
               pos_in    = pos_new;
               moving_in = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.position     = hpos_ff;
               rsp_data_in.velocity     = hrate_ff;
               rsp_data_in.acceleration = haccel_ff;
               rsp_data_in.busy_res     = moving_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         profile_ff   <= PROF_DISABLED;
         rate_lim_ff  <= '0;
         accel_lim_ff <= '0;
         jerk_lim_ff  <= '0;
         tol_ff       <= TOL_RESET;
         period_ff    <= PERIOD_RESET;
         goal_ff      <= '0;
         pos_ff       <= '0;
         rate_ff      <= '0;
         accel_ff     <= '0;
         moving_ff    <= 1'b0;
         hpos_ff      <= '0;
         hrate_ff     <= '0;
         haccel_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         goal_ff      <= goal_in;
         pos_ff       <= pos_in;
         rate_ff      <= rate_in;
         accel_ff     <= accel_in;
         moving_ff    <= moving_in;
         hpos_ff      <= hpos_in;
         hrate_ff     <= hrate_in;
         haccel_ff    <= haccel_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_PROFILE: profile_ff   <= csr_data[1:0];
               CSR_RATE:    rate_lim_ff  <= csr_data[30:0];
               CSR_ACCEL:   accel_lim_ff <= csr_data[30:0];
               CSR_JERK:    jerk_lim_ff  <= csr_data[30:0];
               CSR_TOL:     tol_ff       <= csr_data[30:0];
               CSR_PERIOD:  period_ff    <= csr_data;
               default:     period_ff    <= period_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      dext_ff     <= dext_in;
      dpos_ff     <= dpos_in;
      dneg_ff     <= dneg_in;
      p1_ff       <= p1_in;
      lim_ff      <= lim_in;
      rerr_ff     <= rerr_in;
      adt_ff      <= adt_in;
      tm_ff       <= tm_in;
      step_ff     <= step_in;
      dmag_ff     <= dmag_in;
   end

   `MPG_ASSERT_NEXT(a_accept_decodes, req_valid && req_ready, state_ff == S_DECODE,
      "accepted word did not reach decode")
   `MPG_ASSERT_NOW(a_done_while_launched, arith_done, launched_ff && arith_state,
      "shared unit finished outside a waiting step")
   `MPG_ASSERT_NEXT(a_reset_mode_clears, state_ff == S_DECODE && mode_ff == MODE_RESET,
      rate_ff == 32'sd0 && accel_ff == 32'sd0 && !moving_ff && pos_ff[15:0] == 16'd0,
      "reset to value left motion state")
   `MPG_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff) == S_EMIT,
      "result word raised outside the emit step")

endmodule

// File: dv/mpg_checker.sv
// Checker for the motion profile generator: tracks registers, predicts each result word, compares.
module mpg_checker import mpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam longint VAL_MAX = 64'sd2147483647;
   localparam longint VAL_MIN = -64'sd2147483648;
   localparam longint POS_MAX = (64'sd1 <<< 47) - 1;
   localparam longint POS_MIN = -(64'sd1 <<< 47);
   localparam logic [63:0] MAG_CAP = 64'd1 << 62;

   logic [1:0]  prof_reg;
   logic [63:0] rate_reg, accel_reg, jerk_reg, tol_reg, period_reg;
   longint      goal, plan_pos, plan_rate, plan_accel;
   logic        moving;
   longint      out_pos, out_rate, out_accel;
   rsp_type     setpoint_q[$];

   initial pending = 0;

   function automatic logic [63:0] magn(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint sat_val(longint x);
      return (x > VAL_MAX) ? VAL_MAX : ((x < VAL_MIN) ? VAL_MIN : x);
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // product shifted right, truncated toward zero, magnitude capped
   function automatic longint scale_trunc(longint a, logic [63:0] b, int s);
      logic [127:0] w;
      logic [63:0]  m;
      w = ({64'd0, magn(a)} * {64'd0, b}) >> s;
      m = (w > {64'd0, MAG_CAP}) ? MAG_CAP : w[63:0];
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [63:0] eff_tol();
      return (tol_reg != 0) ? tol_reg : 64'(TOL_DEFAULT);
   endfunction

   function automatic logic [63:0] goal_gap(output int dir);
      longint g;
      g = goal <<< POS_EXTRA;
      if (g > plan_pos) begin
         dir = 1;
         return 64'(g - plan_pos);
      end
      if (g < plan_pos) begin
         dir = -1;
         return 64'(plan_pos - g);
      end
      dir = 0;
      return 0;
   endfunction

   task automatic plan_tick();
      logic [63:0]  dext, span, rm, tm, em, s;
      logic [127:0] reach;
      longint       lim, trate, rerr, step, td, derr, d;
      logic         brake;
      int           dir;
      if (prof_reg == PROF_DISABLED) begin
         out_pos = goal;
         out_rate = 0;
         out_accel = 0;
         moving = 1'b0;
         return;
      end
      if (period_reg <= 64'(HOLD_PERIOD)) return;
      dext = goal_gap(dir);
      span = dext >> POS_EXTRA;
      rm = magn(plan_rate);
      reach = {64'd0, span} * {64'd0, 2 * accel_reg};
      if (accel_reg != 0) brake = reach <= {64'd0, rm} * {64'd0, rm};
      else brake = (span == 0);
      if (brake) begin
         s = root_floor(reach);
         lim = (s > 64'(VAL_MAX)) ? VAL_MAX : longint'(s);
      end else begin
         lim = longint'(rate_reg);
      end
      trate = (dir > 0) ? lim : ((dir < 0) ? -lim : 0);
      rerr = trate - plan_rate;
      if (prof_reg == PROF_TRAP) begin
         step = longint'((accel_reg * period_reg) >> 32);
         if (rerr > step) rerr = step;
         else if (rerr < -step) rerr = -step;
         plan_rate = sat_val(plan_rate + rerr);
         plan_accel = 0;
      end else begin
         em = magn(rerr);
         if (em >= 64'd2147483648 || (em << 32) >= accel_reg * period_reg) tm = accel_reg;
         else tm = (em << 32) / period_reg;
         td = (rerr < 0) ? -longint'(tm) : longint'(tm);
         derr = td - plan_accel;
         step = longint'((jerk_reg * period_reg) >> 32);
         if (derr > step) derr = step;
         else if (derr < -step) derr = -step;
         plan_accel = sat_val(plan_accel + derr);
         plan_rate = sat_val(plan_rate + scale_trunc(plan_accel, period_reg, 32));
      end
      d = scale_trunc(plan_rate, period_reg, 32 - POS_EXTRA);
      plan_pos = plan_pos + d;
      if (plan_pos > POS_MAX) plan_pos = POS_MAX;
      if (plan_pos < POS_MIN) plan_pos = POS_MIN;
      out_pos = plan_pos >>> POS_EXTRA;
      out_rate = plan_rate;
      out_accel = plan_accel;
      // arrival uses the gap from before this step
      if (dext <= (eff_tol() << POS_EXTRA) && magn(plan_rate) <= eff_tol()) begin
         plan_pos = goal <<< POS_EXTRA;
         plan_rate = 0;
         plan_accel = 0;
         moving = 1'b0;
      end else begin
         moving = 1'b1;
      end
   endtask

   task automatic plan_item(req_type w);
      rsp_type e;
      int      dir;
      if (w.mode == MODE_TICK) begin
         plan_tick();
      end else if (w.mode == MODE_TARGET) begin
         goal = longint'(w.value);
         moving = goal_gap(dir) > (eff_tol() << POS_EXTRA);
      end else if (w.mode == MODE_RESET) begin
         goal = longint'(w.value);
         plan_pos = goal <<< POS_EXTRA;
         plan_rate = 0;
         plan_accel = 0;
         moving = 1'b0;
      end
      e.position = out_pos[31:0];
      e.velocity = out_rate[31:0];
      e.acceleration = out_accel[31:0];
      e.busy_res = moving;
      setpoint_q.push_back(e);
   endtask

   task automatic check_word(rsp_type act);
      rsp_type e;
      logic    bad;
      if (setpoint_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result word %h", act);
         return;
      end
      e = setpoint_q.pop_front();
      bad = (act.position !== e.position) || (act.velocity !== e.velocity) ||
            (act.acceleration !== e.acceleration) || (act.busy_res !== e.busy_res);
      if (bad) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch pos %h/%h vel %h/%h acc %h/%h busy %b/%b (exp/act)",
                     e.position, act.position, e.velocity, act.velocity,
                     e.acceleration, act.acceleration, e.busy_res, act.busy_res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         prof_reg <= PROF_DISABLED;
         rate_reg <= 0;
         accel_reg <= 0;
         jerk_reg <= 0;
         tol_reg <= 64'(TOL_RESET);
         period_reg <= 64'(PERIOD_RESET);
         goal = 0;
         plan_pos = 0;
         plan_rate = 0;
         plan_accel = 0;
         moving = 1'b0;
         out_pos = 0;
         out_rate = 0;
         out_accel = 0;
         setpoint_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROFILE: prof_reg <= csr_data[1:0];
               CSR_RATE:    rate_reg <= 64'(csr_data[30:0]);
               CSR_ACCEL:   accel_reg <= 64'(csr_data[30:0]);
               CSR_JERK:    jerk_reg <= 64'(csr_data[30:0]);
               CSR_TOL:     tol_reg <= 64'(csr_data[30:0]);
               CSR_PERIOD:  period_reg <= 64'(csr_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) plan_item(req_data);
         if (rsp_valid && rsp_ready) check_word(rsp_data);
         pending = setpoint_q.size();
      end
   end

endmodule

// File: dv/tb.sv
// Testbench top for the motion profile generator: stimulus, register phases and verdict.
module tb;
   import mpg_pkg::*;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam logic [1:0] PROF_SCURVE  = 2'd2;
   localparam logic [1:0] PROF_ALIAS   = 2'd3;
   localparam int VMAX = 32'h7FFFFFFF;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          fail_count, pending;
   logic        idle_on;
   longint      anchor;
   int          sent;

   motion_profile_generator DUT (.*);

   mpg_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("motion_profile_generator regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
   end

   task automatic send(logic [1:0] m, logic [31:0] v);
      if (idle_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.mode <= m;
      req_data.value <= v;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(logic [1:0] p, logic [31:0] r, logic [31:0] a, logic [31:0] j,
                        logic [31:0] t, logic [31:0] dt);
      write_reg(CSR_PROFILE, p);
      write_reg(CSR_RATE, r);
      write_reg(CSR_ACCEL, a);
      write_reg(CSR_JERK, j);
      write_reg(CSR_TOL, t);
      write_reg(CSR_PERIOD, dt);
   endtask

   // move toward a nearby goal with a run of ticks, with some noise mixed in
   task automatic random_burst();
      int     k;
      longint g;
      k = $urandom_range(99);
      if (k < 8) begin
         anchor = longint'(signed'($urandom()));
         if (k < 4) anchor = anchor >>> 8;
         send(MODE_RESET, anchor[31:0]);
      end else if (k < 12) begin
         send(MODE_IGNORED, $urandom());
      end else if (k < 18) begin
         send(MODE_TARGET, $urandom());
         repeat ($urandom_range(3, 1)) send(MODE_TICK, $urandom());
      end else begin
         g = anchor + longint'($urandom_range(1 << 22)) - (1 << 21);
         if (g > VMAX) g = VMAX;
         if (g < -VMAX - 1) g = -VMAX - 1;
         anchor = g;
         send(MODE_TARGET, g[31:0]);
         repeat ($urandom_range(30, 1)) send(MODE_TICK, $urandom());
      end
   endtask

   initial begin
      logic [31:0] r, a, j, t, dt;
      logic [1:0]  p;
      int          ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_ready = 1'b0;
      idle_on = 1'b1;
      anchor = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // passthrough with reset defaults
      send(MODE_TICK, 32'h0);
      send(MODE_TARGET, 32'h7FFFFFFF);
      send(MODE_TICK, 32'hFFFFFFFF);
      send(MODE_TARGET, 32'h80000000);
      send(MODE_IGNORED, 32'h5A5AA5A5);
      send(MODE_RESET, 32'h0);
      send(MODE_TICK, 32'h0);
      drain();

      // trapezoid, zero tolerance acts as the default
      setup(PROF_TRAP, 32'h0010_0000, 32'h0040_0000, 32'h0, 32'h0, 32'h0400_0000);
      send(MODE_TARGET, 32'h0005_0000);
      repeat (6) send(MODE_TICK, 32'h0);
      send(MODE_TARGET, 32'h0000_0020);
      send(MODE_RESET, 32'h8000_0000);
      send(MODE_TARGET, 32'h7FFF_FFFF);
      send(MODE_TICK, 32'h0);
      drain();

      // s-curve with a hold period: ticks change nothing
      setup(PROF_SCURVE, 32'h0010_0000, 32'h0040_0000, 32'h0100_0000, 32'd1, HOLD_PERIOD);
      send(MODE_TARGET, 32'h0003_0000);
      send(MODE_TICK, 32'h0);
      send(MODE_TICK, 32'h0);
      drain();

      ph = 0;
      while (sent < 650) begin
         p = (ph % 4 == 0) ? PROF_TRAP : (ph % 4 == 1) ? PROF_SCURVE :
             (ph % 4 == 2) ? PROF_ALIAS : PROF_DISABLED;
         if (ph % 7 == 3) p = PROF_TRAP;
         case (ph % 6)
            0: begin
               r = 32'h7FFFFFFF; a = 32'h7FFFFFFF; j = 32'h7FFFFFFF;
               t = 32'h7FFFFFFF; dt = 32'hFFFFFFFF;
            end
            1: begin
               r = 0; a = 0; j = 0; t = 0; dt = $urandom_range(32'h0800_0000, 32'h0010_0000);
            end
            2: begin
               r = $urandom(); a = $urandom(); j = $urandom(); t = $urandom();
               dt = ($urandom_range(1)) ? HOLD_PERIOD + 1 : $urandom_range(HOLD_PERIOD);
            end
            default: begin
               r = $urandom_range(32'h0100_0000, 32'h0001_0000);
               a = $urandom_range(32'h0400_0000, 32'h0004_0000);
               j = $urandom_range(32'h4000_0000, 32'h0010_0000);
               t = $urandom_range(32'h0002_0000, 1);
               dt = $urandom_range(32'h0800_0000, 32'h0100_0000);
            end
         endcase
         drain();
         setup(p, r, a, j, t, dt);
         idle_on = (ph != 4);
         repeat (6) if (sent < 650) random_burst();
         ph++;
      end
      drain();
      idle_on = 1'b1;

      if (fail_count == 0) begin
         $display("motion_profile_generator regression: pass");
      end else begin
         $display("motion_profile_generator regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mpg_pkg.sv
hw/rtl/mpg_arith.sv
hw/rtl/motion_profile_generator.sv
dv/mpg_checker.sv
dv/tb.sv
